@@ rtl/ppp_pkg.sv @@
// ---------------------------------------------------------------------------
// ppp_pkg
// Types, widths and codes shared by the point projection pipeline.
// ---------------------------------------------------------------------------
package ppp_pkg;

   localparam int PointWidth  = 32;
   localparam int RotWidth    = 18;
   localparam int RowWidth    = 3 * RotWidth;
   localparam int ProdWidth   = PointWidth + RotWidth;
   localparam int AccWidth    = 53;
   localparam int CamWidth    = 37;
   localparam int CamOutWidth = 48;
   localparam int FocalWidth  = 20;
   localparam int CenterWidth = 21;
   localparam int SizeWidth   = 13;
   localparam int PixelWidth  = 32;
   localparam int NumWidth    = FocalWidth + 1 + CamWidth;
   localparam int MagWidth    = NumWidth - 1;
   localparam int DivBits     = 35;
   localparam int DenWidth    = CamWidth + 1;
   localparam int RemWidth    = DenWidth + DivBits + 1;
   localparam int SumWidth    = DivBits + 2;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDatWidth = 21;

   typedef enum logic [1:0] {
      ST_VALID    = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_BEHIND   = 2'd2,
      ST_OUTSIDE  = 2'd3
   } status_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_FOCAL_X  = 3'd0,
      REG_FOCAL_Y  = 3'd1,
      REG_CENTER_X = 3'd2,
      REG_CENTER_Y = 3'd3,
      REG_WIDTH    = 3'd4,
      REG_HEIGHT   = 3'd5
   } csr_index_type;

   localparam logic [FocalWidth-1:0]  FocalXReset  = 20'd128000;
   localparam logic [FocalWidth-1:0]  FocalYReset  = 20'd128000;
   localparam logic [CenterWidth-1:0] CenterXReset = 21'd81920;
   localparam logic [CenterWidth-1:0] CenterYReset = 21'd61440;
   localparam logic [SizeWidth-1:0]   WidthReset   = 13'd640;
   localparam logic [SizeWidth-1:0]   HeightReset  = 13'd480;

endpackage

@@ rtl/pinhole_point_projection_top.sv @@
// ---------------------------------------------------------------------------
// pinhole_point_projection_top
// Fixed point pinhole projection: camera point R*p+t, then f*x/z+c per axis
// with bounds check, one word per cycle through a 40 stage pipeline.
//
//   channel   | handshake            | payload
//   ----------+----------------------+----------------------------------------
//   request   | start / busy         | req_point_*, req_rot_row*, req_trans_*
//   response  | rsp_valid strobe     | rsp_proj_status, rsp_cam_*, rsp_pixel_*
//   csr       | csr_valid/csr_ready  | csr_index, csr_data
//
// one word can enter every cycle; busy stays low
// stages: 4 arithmetic stages, 35 quotient bit stages, output
// the divider retires one quotient bit per stage for both axes
// synchronous reset clears the valid bits and loads the csr registers with their reset values
// the receiver cannot stall, so the pipeline always advances
// ---------------------------------------------------------------------------
module pinhole_point_projection_top
   import ppp_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [PointWidth-1:0]  req_point_x,
   input  logic signed [PointWidth-1:0]  req_point_y,
   input  logic signed [PointWidth-1:0]  req_point_z,
   input  logic [RowWidth-1:0]           req_rot_row0,
   input  logic [RowWidth-1:0]           req_rot_row1,
   input  logic [RowWidth-1:0]           req_rot_row2,
   input  logic signed [PointWidth-1:0]  req_trans_x,
   input  logic signed [PointWidth-1:0]  req_trans_y,
   input  logic signed [PointWidth-1:0]  req_trans_z,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_proj_status,
   output logic signed [CamOutWidth-1:0] rsp_cam_x,
   output logic signed [CamOutWidth-1:0] rsp_cam_y,
   output logic signed [CamOutWidth-1:0] rsp_cam_z,
   output logic signed [PixelWidth-1:0]  rsp_pixel_x,
   output logic signed [PixelWidth-1:0]  rsp_pixel_y,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CsrIdxWidth-1:0]        csr_index,
   input  logic [CsrDatWidth-1:0]        csr_data
);

   // csr registers
   logic [FocalWidth-1:0]  focal_x_ff, focal_y_ff;
   logic [CenterWidth-1:0] center_x_ff, center_y_ff;
   logic [SizeWidth-1:0]   width_ff, height_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= FocalXReset;
         focal_y_ff  <= FocalYReset;
         center_x_ff <= CenterXReset;
         center_y_ff <= CenterYReset;
         width_ff    <= WidthReset;
         height_ff   <= HeightReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FOCAL_X:  focal_x_ff  <= csr_data[FocalWidth-1:0];
            REG_FOCAL_Y:  focal_y_ff  <= csr_data[FocalWidth-1:0];
            REG_CENTER_X: center_x_ff <= csr_data;
            REG_CENTER_Y: center_y_ff <= csr_data;
            REG_WIDTH:    width_ff    <= csr_data[SizeWidth-1:0];
            REG_HEIGHT:   height_ff   <= csr_data[SizeWidth-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: rotation products
   logic [RowWidth-1:0]          rows [3];
   logic signed [PointWidth-1:0] pts  [3];
   logic signed [PointWidth-1:0] trs  [3];
   logic signed [ProdWidth-1:0]  prod_in [3][3];
   logic signed [ProdWidth-1:0]  prod_ff [3][3];
   logic signed [PointWidth-1:0] trans_ff [3];
   logic                         s1_valid_ff;

   assign rows = '{req_rot_row0, req_rot_row1, req_rot_row2};
   assign pts  = '{req_point_x, req_point_y, req_point_z};
   assign trs  = '{req_trans_x, req_trans_y, req_trans_z};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = $signed(rows[i][RotWidth*j +: RotWidth]) * pts[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      trans_ff <= trs;
   end

   // stage 2: sum, add translation, round to q16
   logic signed [AccWidth-1:0] acc_in [3];
   logic signed [CamWidth-1:0] cam_ff [3];
   logic                       s2_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = AccWidth'(trans_ff[i]) * AccWidth'(65536)
                   + AccWidth'(prod_ff[i][0]) + AccWidth'(prod_ff[i][1])
                   + AccWidth'(prod_ff[i][2]) + AccWidth'(32768);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         cam_ff[i] <= acc_in[i][AccWidth-1:16];
      end
   end

   // stage 3: focal products
   logic signed [NumWidth-1:0] numx_ff, numy_ff;
   logic signed [CamWidth-1:0] cam3_ff [3];
   logic                       s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      numx_ff <= $signed({1'b0, focal_x_ff}) * cam_ff[0];
      numy_ff <= $signed({1'b0, focal_y_ff}) * cam_ff[1];
      cam3_ff <= cam_ff;
   end

   // stage 4: magnitudes and divider operands
   logic [MagWidth-1:0] magx, magy;
   logic [RemWidth-1:0] remx_d [DivBits+1];
   logic [RemWidth-1:0] remy_d [DivBits+1];
   logic [DenWidth-1:0] den_d  [DivBits+1];
   logic [DivBits-1:0]  qx_d   [DivBits+1];
   logic [DivBits-1:0]  qy_d   [DivBits+1];
   logic                negx_d [DivBits+1];
   logic                negy_d [DivBits+1];
   logic signed [CamWidth-1:0] camd [DivBits+1][3];
   logic                vld_d  [DivBits+1];

   assign magx = numx_ff[NumWidth-1] ? MagWidth'(-numx_ff) : numx_ff[MagWidth-1:0];
   assign magy = numy_ff[NumWidth-1] ? MagWidth'(-numy_ff) : numy_ff[MagWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_d[0] <= 1'b0;
      end else begin
         vld_d[0] <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      remx_d[0] <= RemWidth'({magx, 1'b0}) + RemWidth'(unsigned'(cam3_ff[2]));
      remy_d[0] <= RemWidth'({magy, 1'b0}) + RemWidth'(unsigned'(cam3_ff[2]));
      den_d[0]  <= {cam3_ff[2][CamWidth-1:0], 1'b0};
      qx_d[0]   <= '0;
      qy_d[0]   <= '0;
      negx_d[0] <= numx_ff[NumWidth-1];
      negy_d[0] <= numy_ff[NumWidth-1];
      camd[0]   <= cam3_ff;
   end

   // quotient bit stages, msb first
   for (genvar k = 0; k < DivBits; k++) begin : g_div
      localparam int Shift = DivBits - 1 - k;
      logic [RemWidth-1:0] dsh;
      logic                gex, gey;

      assign dsh = RemWidth'(den_d[k]) << Shift;
      assign gex = remx_d[k] >= dsh;
      assign gey = remy_d[k] >= dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_d[k+1] <= 1'b0;
         end else begin
            vld_d[k+1] <= vld_d[k];
         end
      end

      always_ff @(posedge clock) begin
         remx_d[k+1] <= gex ? remx_d[k] - dsh : remx_d[k];
         remy_d[k+1] <= gey ? remy_d[k] - dsh : remy_d[k];
         qx_d[k+1]   <= {qx_d[k][DivBits-2:0], gex};
         qy_d[k+1]   <= {qy_d[k][DivBits-2:0], gey};
         den_d[k+1]  <= den_d[k];
         negx_d[k+1] <= negx_d[k];
         negy_d[k+1] <= negy_d[k];
         camd[k+1]   <= camd[k];
      end
   end

   // output stage: sign, centre, range and bounds
   logic [DivBits-1:0]         qx, qy;
   logic signed [SumWidth-1:0] pix, piy;
   logic                       behind, ovf, outside;
   logic [1:0]                 status_in;
   logic signed [CamWidth-1:0] camf [3];

   assign qx   = qx_d[DivBits];
   assign qy   = qy_d[DivBits];
   assign camf = camd[DivBits];

   always_comb begin
      pix = (negx_d[DivBits] ? -$signed({2'b00, qx}) : $signed({2'b00, qx}))
          + SumWidth'($signed(center_x_ff));
      piy = (negy_d[DivBits] ? -$signed({2'b00, qy}) : $signed({2'b00, qy}))
          + SumWidth'($signed(center_y_ff));
      behind  = camf[2] <= 0;
      ovf     = qx[DivBits-1] || qy[DivBits-1]
             || (pix[SumWidth-1:PixelWidth-1] != {(SumWidth-PixelWidth+1){pix[SumWidth-1]}})
             || (piy[SumWidth-1:PixelWidth-1] != {(SumWidth-PixelWidth+1){piy[SumWidth-1]}});
      outside = pix[SumWidth-1] || piy[SumWidth-1]
             || (pix >= $signed(SumWidth'({width_ff, 8'h00})))
             || (piy >= $signed(SumWidth'({height_ff, 8'h00})));
      if (behind) begin
         status_in = ST_BEHIND;
      end else if (ovf) begin
         status_in = ST_OVERFLOW;
      end else if (outside) begin
         status_in = ST_OUTSIDE;
      end else begin
         status_in = ST_VALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= vld_d[DivBits];
      end
   end

   always_ff @(posedge clock) begin
      rsp_proj_status <= status_in;
      rsp_cam_x       <= CamOutWidth'(camf[0]);
      rsp_cam_y       <= CamOutWidth'(camf[1]);
      rsp_cam_z       <= CamOutWidth'(camf[2]);
      if (behind || ovf) begin
         rsp_pixel_x <= '0;
         rsp_pixel_y <= '0;
      end else begin
         rsp_pixel_x <= pix[PixelWidth-1:0];
         rsp_pixel_y <= piy[PixelWidth-1:0];
      end
   end

endmodule

@@ bench/pinhole_point_projection_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pinhole_point_projection_checker
// Watches the request, response and csr channels, predicts each response
// word from the accepted request and the current settings, and compares.
// ---------------------------------------------------------------------------
module pinhole_point_projection_checker
   import ppp_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic signed [PointWidth-1:0]  req_point_x,
   input  logic signed [PointWidth-1:0]  req_point_y,
   input  logic signed [PointWidth-1:0]  req_point_z,
   input  logic [RowWidth-1:0]           req_rot_row0,
   input  logic [RowWidth-1:0]           req_rot_row1,
   input  logic [RowWidth-1:0]           req_rot_row2,
   input  logic signed [PointWidth-1:0]  req_trans_x,
   input  logic signed [PointWidth-1:0]  req_trans_y,
   input  logic signed [PointWidth-1:0]  req_trans_z,
   input  logic                          rsp_valid,
   input  logic [1:0]                    rsp_proj_status,
   input  logic signed [CamOutWidth-1:0] rsp_cam_x,
   input  logic signed [CamOutWidth-1:0] rsp_cam_y,
   input  logic signed [CamOutWidth-1:0] rsp_cam_z,
   input  logic signed [PixelWidth-1:0]  rsp_pixel_x,
   input  logic signed [PixelWidth-1:0]  rsp_pixel_y,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CsrIdxWidth-1:0]        csr_index,
   input  logic [CsrDatWidth-1:0]        csr_data,
   output int                            errors,
   output int                            pending,
   output int                            seen
);

   typedef struct packed {
      logic [1:0]             status;
      logic [CamOutWidth-1:0] cx, cy, cz;
      logic [PixelWidth-1:0]  px, py;
   } projection_word;

   projection_word projections[$];
   logic [FocalWidth-1:0]  fx, fy;
   logic [CenterWidth-1:0] ctr_x, ctr_y;
   logic [SizeWidth-1:0]   img_w, img_h;

   assign pending = projections.size();

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic logic signed [63:0] rot_at(input logic [RowWidth-1:0] row, input int col);
      logic signed [RotWidth-1:0] e;
      e = row[col*RotWidth +: RotWidth];
      return 64'(e);
   endfunction

   function automatic logic signed [63:0] to_q16(input logic signed [63:0] v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic logic signed [63:0] axis_pixel(input logic [FocalWidth-1:0] f,
         input logic signed [63:0] num, input logic signed [63:0] den,
         input logic [CenterWidth-1:0] c);
      logic signed [63:0] n, r;
      logic [63:0] mag, q;
      logic signed [CenterWidth-1:0] cs;
      n = $signed({44'd0, f}) * num;
      mag = n < 0 ? -n : n;
      q = (2 * mag + den) / (2 * den);
      r = n < 0 ? -$signed(q) : $signed(q);
      cs = c;
      return r + 64'(cs);
   endfunction

   function automatic projection_word project_point();
      projection_word w;
      logic signed [63:0] p[3], t[3], cam[3], acc, px, py;
      logic [RowWidth-1:0] rows[3];
      p[0] = req_point_x; p[1] = req_point_y; p[2] = req_point_z;
      t[0] = req_trans_x; t[1] = req_trans_y; t[2] = req_trans_z;
      rows[0] = req_rot_row0; rows[1] = req_rot_row1; rows[2] = req_rot_row2;
      for (int i = 0; i < 3; i++) begin
         acc = t[i] * 64'sd65536;
         for (int j = 0; j < 3; j++) acc += rot_at(rows[i], j) * p[j];
         cam[i] = to_q16(acc);
      end
      px = 0; py = 0;
      if (cam[2] <= 0) begin
         w.status = ST_BEHIND;
      end else begin
         px = axis_pixel(fx, cam[0], cam[2], ctr_x);
         py = axis_pixel(fy, cam[1], cam[2], ctr_y);
         if (px < -(64'sd1 <<< 31) || px > (64'sd1 <<< 31) - 1 ||
               py < -(64'sd1 <<< 31) || py > (64'sd1 <<< 31) - 1) begin
            w.status = ST_OVERFLOW;
            px = 0; py = 0;
         end else if (px < 0 || px >= 64'(img_w) * 256 || py < 0 || py >= 64'(img_h) * 256) begin
            w.status = ST_OUTSIDE;
         end else begin
            w.status = ST_VALID;
         end
      end
      w.cx = cam[0][47:0]; w.cy = cam[1][47:0]; w.cz = cam[2][47:0];
      w.px = px[31:0]; w.py = py[31:0];
      return w;
   endfunction

   initial begin
      errors = 0;
      seen = 0;
   end

   always @(posedge clock) begin
      projection_word w;
      if (reset) begin
         fx = FocalXReset; fy = FocalYReset;
         ctr_x = CenterXReset; ctr_y = CenterYReset;
         img_w = WidthReset; img_h = HeightReset;
      end else begin
         if (rsp_valid) begin
            seen++;
            if (projections.size() == 0) begin
               report("unexpected word", rsp_proj_status, 0);
            end else begin
               w = projections.pop_front();
               if (rsp_proj_status !== w.status) report("status", rsp_proj_status, w.status);
               if (rsp_cam_x !== w.cx) report("cam_x", rsp_cam_x, w.cx);
               if (rsp_cam_y !== w.cy) report("cam_y", rsp_cam_y, w.cy);
               if (rsp_cam_z !== w.cz) report("cam_z", rsp_cam_z, w.cz);
               if (rsp_pixel_x !== w.px) report("pixel_x", rsp_pixel_x, w.px);
               if (rsp_pixel_y !== w.py) report("pixel_y", rsp_pixel_y, w.py);
            end
         end
         if (start && !busy) projections.push_back(project_point());
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FOCAL_X:  fx = csr_data[FocalWidth-1:0];
               REG_FOCAL_Y:  fy = csr_data[FocalWidth-1:0];
               REG_CENTER_X: ctr_x = csr_data;
               REG_CENTER_Y: ctr_y = csr_data;
               REG_WIDTH:    img_w = csr_data[SizeWidth-1:0];
               REG_HEIGHT:   img_h = csr_data[SizeWidth-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

@@ bench/pinhole_point_projection_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pinhole_point_projection_top_tb
// Drives directed and random points and poses through the projection
// pipeline under several camera settings; a checker predicts every word.
// ---------------------------------------------------------------------------
module pinhole_point_projection_top_tb;
   import ppp_pkg::*;

   localparam int Latency = 40;
   localparam int Limit = 2000;

   logic clock = 0, reset = 1, start = 0, busy;
   logic signed [PointWidth-1:0] req_point_x = 0, req_point_y = 0, req_point_z = 0;
   logic [RowWidth-1:0] req_rot_row0 = 0, req_rot_row1 = 0, req_rot_row2 = 0;
   logic signed [PointWidth-1:0] req_trans_x = 0, req_trans_y = 0, req_trans_z = 0;
   logic rsp_valid;
   logic [1:0] rsp_proj_status;
   logic signed [CamOutWidth-1:0] rsp_cam_x, rsp_cam_y, rsp_cam_z;
   logic signed [PixelWidth-1:0] rsp_pixel_x, rsp_pixel_y;
   logic csr_valid = 0, csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = 0;
   logic [CsrDatWidth-1:0] csr_data = 0;
   int errors, pending, seen, quiet, sent, idle_pct;

   always #1 clock = ~clock;

   pinhole_point_projection_top dut (.*);
   pinhole_point_projection_checker checker_i (.*);

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > Limit) begin
         $display("watchdog expired");
         $display("pinhole_point_projection_top_tb: errors");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CsrDatWidth-1:0] v);
      csr_valid <= 1; csr_index <= idx; csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (Latency + 5) @(negedge clock);
   endtask

   task automatic send(input logic [31:0] px, py, pz, input logic [53:0] r0, r1, r2,
         input logic [31:0] tx, ty, tz);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_point_x <= px; req_point_y <= py; req_point_z <= pz;
      req_rot_row0 <= r0; req_rot_row1 <= r1; req_rot_row2 <= r2;
      req_trans_x <= tx; req_trans_y <= ty; req_trans_z <= tz;
      do @(posedge clock); while (busy);
      sent++;
      @(negedge clock);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) start <= 0;
   endtask

   function automatic logic [53:0] row_of(input logic [17:0] a, b, c);
      return {c, b, a};
   endfunction

   function automatic logic [31:0] rnd_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
         default: return 32'($signed($urandom_range(200000)) - 100000) <<< 8;
      endcase
   endfunction

   function automatic logic [17:0] rnd_rot();
      if ($urandom_range(3) == 0) return 18'($urandom);
      return 18'($signed($urandom_range(131072)) - 65536);
   endfunction

   task automatic random_item();
      logic [17:0] one;
      one = 18'h10000;
      if ($urandom_range(4) == 0)
         send(rnd_coord(), rnd_coord(), rnd_coord(),
              row_of(rnd_rot(), rnd_rot(), rnd_rot()), row_of(rnd_rot(), rnd_rot(), rnd_rot()),
              row_of(rnd_rot(), rnd_rot(), rnd_rot()), $urandom, $urandom, $urandom);
      else
         send(rnd_coord(), rnd_coord(), 32'($urandom_range(3000, 1)) <<< 12,
              row_of(one, rnd_rot() >>> 4, rnd_rot() >>> 4),
              row_of(rnd_rot() >>> 4, one, rnd_rot() >>> 4),
              row_of(rnd_rot() >>> 4, rnd_rot() >>> 4, one),
              rnd_coord(), rnd_coord(), 32'($urandom_range(65536)));
   endtask

   initial begin
      logic [53:0] eye;
      eye = 0;
      quiet = 0; sent = 0; idle_pct = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed words at reset settings
      eye = row_of(18'h10000, 0, 0);
      send(32'h10000, 32'h10000, 32'h100000, eye, row_of(0, 18'h10000, 0),
           row_of(0, 0, 18'h10000), 0, 0, 0);
      send(0, 0, 0, eye, row_of(0, 18'h10000, 0), row_of(0, 0, 18'h10000), 0, 0, 0);
      send(0, 0, 32'h80000000, eye, row_of(0, 18'h10000, 0), row_of(0, 0, 18'h10000), 0, 0, 0);
      send(32'h7fffffff, 32'h7fffffff, 1, eye, row_of(0, 18'h10000, 0),
           row_of(0, 0, 18'h10000), 0, 0, 0);
      send(32'h80000000, 32'h80000000, 32'h80000000, {3{18'h20000}}, {3{18'h20000}},
           {3{18'h20000}}, 32'h80000000, 32'h80000000, 32'h80000000);
      send(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, {3{18'h1ffff}}, {3{18'h1ffff}},
           {3{18'h1ffff}}, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send(32'hffffffff, 32'hffffffff, 32'hffffffff, {54{1'b1}}, {54{1'b1}}, {54{1'b1}},
           32'hffffffff, 32'hffffffff, 32'hffffffff);
      send(32'h01000000, 0, 32'h10000, eye, row_of(0, 18'h10000, 0),
           row_of(0, 0, 18'h10000), 0, 0, 0);
      send(32'h8000, 32'h8000, 32'h10000, eye, row_of(0, 18'h10000, 0),
           row_of(0, 0, 18'h10000), 0, 0, 32'h8000);
      send(0, 0, 0, 0, 0, 0, 0, 0, 1);
      start <= 0;
      drain();
      // extreme, random and typical settings
      for (int s = 0; s < 5; s++) begin
         case (s)
            0: begin
               write_reg(REG_FOCAL_X, 0); write_reg(REG_FOCAL_Y, 0);
               write_reg(REG_CENTER_X, 21'h100000); write_reg(REG_CENTER_Y, 21'h0fffff);
               write_reg(REG_WIDTH, 0); write_reg(REG_HEIGHT, 13'd4096);
            end
            1: begin
               write_reg(REG_FOCAL_X, 20'hfffff); write_reg(REG_FOCAL_Y, 20'hfffff);
               write_reg(REG_CENTER_X, 0); write_reg(REG_CENTER_Y, 21'h1fffff);
               write_reg(REG_WIDTH, 13'h1fff); write_reg(REG_HEIGHT, 1);
               write_reg(csr_index_type'(3'd7), 21'h1fffff);
            end
            2: begin
               write_reg(REG_FOCAL_X, 1); write_reg(REG_FOCAL_Y, 1);
               write_reg(REG_CENTER_X, 21'd256); write_reg(REG_CENTER_Y, 21'd256);
               write_reg(REG_WIDTH, 13'd2); write_reg(REG_HEIGHT, 13'd2);
            end
            3: begin
               write_reg(REG_FOCAL_X, 20'($urandom)); write_reg(REG_FOCAL_Y, 20'($urandom));
               write_reg(REG_CENTER_X, 21'($urandom)); write_reg(REG_CENTER_Y, 21'($urandom));
               write_reg(REG_WIDTH, 13'($urandom)); write_reg(REG_HEIGHT, 13'($urandom));
               write_reg(csr_index_type'(3'd6), 0);
            end
            default: begin
               write_reg(REG_FOCAL_X, 20'd128000); write_reg(REG_FOCAL_Y, 20'd96000);
               write_reg(REG_CENTER_X, 21'd163840); write_reg(REG_CENTER_Y, 21'd122880);
               write_reg(REG_WIDTH, 13'd1280); write_reg(REG_HEIGHT, 13'd960);
            end
         endcase
         idle_pct = (s == 1) ? 0 : 13;
         for (int k = 0; k < 100; k++) begin
            random_item();
            if (k == 50) begin
               start <= 0;
               drain();
            end
         end
         start <= 0;
         drain();
      end
      $display("sent %0d words over six settings, %0d responses checked", sent, seen);
      if (errors == 0) begin
         $display("pinhole_point_projection_top_tb: clean");
      end else begin
         $display("pinhole_point_projection_top_tb: errors");
      end
      $finish;
   end

endmodule
